// ----- design/assert_macros.svh -----
// Assertion macros shared by the colormap unit modules.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ADCM_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("adcm: implication violated");

// Invariant checked on every rising edge outside reset.
`define ADCM_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("adcm: invariant violated");

`endif

// ----- design/adcm_pkg.sv -----
// Shared constants, types and ramp functions of the deviation colormap unit.
// No dependencies; every other file but assert_macros.svh imports it.
package adcm_pkg;

	localparam int DEPTH      = 64;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DEV_W      = 32;
	localparam int MEM_W      = DEV_W + 1;
	localparam int U_W        = 18;
	localparam int DIV_CNT_W  = $clog2(U_W);
	localparam int CFG_IDX_W  = 2;
	localparam int FQ_DEPTH   = 2;
	localparam int FQ_PTR_W   = 1;

	// Register map of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_ENABLE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_MIN    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_MAX    = CFG_IDX_W'(2);

	// Ramp position with 8 fraction bits, full scale 1020.
	localparam logic [U_W-1:0] SEG1_U = U_W'(65280);
	localparam logic [U_W-1:0] SEG2_U = U_W'(130560);
	localparam logic [U_W-1:0] SEG3_U = U_W'(195840);
	localparam logic [U_W-1:0] UMAX_U = U_W'(261120);
	localparam logic [U_W-1:0] HALF_U = U_W'(128);

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [MEM_W-1:0] data;   // {finite, deviation}
	} mem_wr_t;

	typedef struct packed {
		logic [DEV_W-1:0] lo;
		logic [DEV_W-1:0] hi;
		logic [CNT_W-1:0] count;
		logic             trunc;
	} job_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	localparam rgb_t GREEN_RGB = '{r: 8'd0, g: 8'd255, b: 8'd0};

	// Round half up to a byte, saturate at 255.
	function automatic logic [7:0] rnd_byte(logic [U_W-1:0] x);
		logic [U_W:0] s;
		s = {1'b0, x} + {1'b0, HALF_U};
		if (s[U_W:8] > (U_W - 7)'(255)) begin
			return 8'd255;
		end
		return s[15:8];
	endfunction

	// Blue-cyan-green-yellow-red ramp over u in [0, UMAX_U].
	function automatic rgb_t ramp_color(logic [U_W-1:0] u);
		rgb_t c;
		c = '0;
		if (u < SEG1_U) begin
			c.b = 8'd255;
			c.g = rnd_byte(u);
		end else if (u < SEG2_U) begin
			c.g = 8'd255;
			c.b = rnd_byte(SEG2_U - u);
		end else if (u < SEG3_U) begin
			c.g = 8'd255;
			c.r = rnd_byte(u - SEG2_U);
		end else begin
			c.r = 8'd255;
			c.g = rnd_byte(UMAX_U - u);
		end
		return c;
	endfunction

endpackage

// ----- design/adcm_stream_ifs.sv -----
// Handshake channel interfaces of the deviation colormap unit.
// Depends on adcm_pkg for the configuration index width.
interface adcm_item_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] deviation;
	logic              finite;
	logic              set_last;
	modport source(output valid, deviation, finite, set_last, input ready);
	modport sink(input valid, deviation, finite, set_last, output ready);
endinterface

interface adcm_color_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       truncated;
	logic       run_last;
	modport source(output valid, red, green, blue, truncated, run_last, input ready);
	modport sink(input valid, red, green, blue, truncated, run_last, output ready);
endinterface

interface adcm_cfg_if import adcm_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- design/adcm_front.sv -----
// Front end: takes in the set, writes the value store, tracks bounds and
// hands one job per set to the back end. Depends on adcm_pkg, adcm_item_if.
`include "assert_macros.svh"

module adcm_front import adcm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	adcm_item_if.sink               item,
	input  logic                    manual_enable,
	input  logic signed [DEV_W-1:0] manual_min,
	input  logic signed [DEV_W-1:0] manual_max,
	output mem_wr_t                 mem_wr,
	output job_t                    job,
	output logic                    job_valid,
	input  logic                    job_ready,
	input  logic                    done
);

	logic [CNT_W-1:0]        count_q;
	logic signed [DEV_W-1:0] range_low_q;
	logic signed [DEV_W-1:0] range_high_q;
	logic                    seen_q;
	logic                    overflow_q;
	logic                    pending_q;

	logic                    accept;
	logic                    store;
	logic signed [DEV_W-1:0] low_n;
	logic signed [DEV_W-1:0] high_n;
	logic                    seen_n;
	logic [CNT_W-1:0]        count_n;
	logic                    overflow_n;
	logic                    manual_ok;

	// Hold off the next set until the back end has drained the store.
	assign item.ready = !pending_q && job_ready;

	always_comb begin
		accept     = item.valid && item.ready;
		store      = accept && (count_q < CNT_W'(DEPTH));
		low_n      = range_low_q;
		high_n     = range_high_q;
		seen_n     = seen_q;
		if (store && item.finite) begin
			if (!seen_q) begin
				low_n  = item.deviation;
				high_n = item.deviation;
			end else begin
				if (item.deviation < range_low_q) begin
					low_n = item.deviation;
				end
				if (item.deviation > range_high_q) begin
					high_n = item.deviation;
				end
			end
			seen_n = 1'b1;
		end
		count_n    = count_q + CNT_W'(store);
		overflow_n = overflow_q || (accept && !store);
		manual_ok  = manual_enable && (manual_min <= manual_max);

		if (manual_ok) begin
			job.lo = manual_min;
			job.hi = manual_max;
		end else if (seen_n) begin
			job.lo = low_n;
			job.hi = high_n;
		end else begin
			job.lo = '0;
			job.hi = '0;
		end
		job.count = count_n;
		job.trunc = overflow_n;
		job_valid = accept && item.set_last;

		mem_wr.en   = store;
		mem_wr.addr = count_q[IDX_W-1:0];
		mem_wr.data = {item.finite, item.deviation};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			range_low_q  <= '0;
			range_high_q <= '0;
			seen_q       <= 1'b0;
			overflow_q   <= 1'b0;
			pending_q    <= 1'b0;
		end else begin
			if (done) begin
				pending_q <= 1'b0;
			end
			if (accept) begin
				if (item.set_last) begin
					count_q      <= '0;
					range_low_q  <= '0;
					range_high_q <= '0;
					seen_q       <= 1'b0;
					overflow_q   <= 1'b0;
					pending_q    <= 1'b1;
				end else begin
					count_q      <= count_n;
					range_low_q  <= low_n;
					range_high_q <= high_n;
					seen_q       <= seen_n;
					overflow_q   <= overflow_n;
				end
			end
		end
	end

	`ADCM_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH))
	`ADCM_ASSERT_IMP(a_done_needs_pending, done, pending_q)
	`ADCM_ASSERT_IMP(a_job_not_empty, job_valid, job.count != '0)

endmodule

// ----- design/adcm_job_fifo.sv -----
// Two-entry job queue between front and back end.
// Depends on adcm_pkg for job_t.
module adcm_job_fifo import adcm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t push_job,
	input  logic push_valid,
	output logic push_ready,
	output job_t pop_job,
	output logic pop_valid,
	input  logic pop_ready
);

	job_t                slot_q [FQ_DEPTH];
	logic [FQ_PTR_W-1:0] wr_ptr_q;
	logic [FQ_PTR_W-1:0] rd_ptr_q;
	logic [FQ_PTR_W:0]   fill_q;
	logic                push;
	logic                pop;

	assign push_ready = (fill_q != (FQ_PTR_W + 1)'(FQ_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_job    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FQ_PTR_W'(1);
			end
			fill_q <= fill_q + (FQ_PTR_W + 1)'(push) - (FQ_PTR_W + 1)'(pop);
		end
	end

endmodule

// ----- design/adcm_back.sv -----
// Back end: value store, bit-serial divider and ramp lookup; emits one
// colour per stored item. Depends on adcm_pkg and adcm_color_if.
`include "assert_macros.svh"

module adcm_back import adcm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  mem_wr_t      mem_wr,
	input  job_t         job,
	input  logic         job_valid,
	output logic         job_ready,
	output logic         done,
	adcm_color_if.source color
);

	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_LOAD,
		B_MUL,
		B_DIV,
		B_COLOR
	} bstate_t;

	localparam int PROD_W = DEV_W + U_W;

	bstate_t              state_q;
	logic [MEM_W-1:0]     store_q [DEPTH];
	logic [MEM_W-1:0]     rd_data_q;
	logic [CNT_W-1:0]     idx_q;
	logic                 out_valid_q;
	rgb_t                 out_rgb_q;
	logic                 out_trunc_q;
	logic                 out_last_q;
	logic                 done_q;

	logic [DEV_W-1:0]     lo_q;
	logic [DEV_W-1:0]     hi_q;
	logic [CNT_W-1:0]     count_q;
	logic                 trunc_q;
	logic [DEV_W:0]       span_q;
	logic [DEV_W-1:0]     diff_q;
	logic                 green_q;
	logic [DEV_W-1:0]     rem_q;
	logic [U_W-1:0]       num_lo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic [DEV_W-1:0]     d_w;
	logic                 fin_w;
	logic [DEV_W:0]       diff_w;
	logic [DEV_W:0]       span_w;
	logic                 span_pos_w;
	logic                 green_w;
	logic                 le_w;
	logic                 ge_w;
	logic [PROD_W-1:0]    prod_w;
	logic [DEV_W:0]       trial_w;
	logic                 take_w;
	logic [DEV_W:0]       sub_w;
	rgb_t                 rgb_w;
	logic [CNT_W-1:0]     idx_next_w;
	logic                 last_w;
	logic                 load_out_w;

	assign job_ready       = (state_q == B_IDLE);
	assign done            = done_q;
	assign color.valid     = out_valid_q;
	assign color.red       = out_rgb_q.r;
	assign color.green     = out_rgb_q.g;
	assign color.blue      = out_rgb_q.b;
	assign color.truncated = out_trunc_q;
	assign color.run_last  = out_last_q;

	always_comb begin
		d_w        = rd_data_q[DEV_W-1:0];
		fin_w      = rd_data_q[DEV_W];
		diff_w     = {d_w[DEV_W-1], d_w} - {lo_q[DEV_W-1], lo_q};
		span_w     = {job.hi[DEV_W-1], job.hi} - {job.lo[DEV_W-1], job.lo};
		span_pos_w = !span_q[DEV_W] && (span_q != '0);
		green_w    = !fin_w || !span_pos_w;
		le_w       = diff_w[DEV_W] || (diff_w == '0);
		ge_w       = ($signed(d_w) >= $signed(hi_q));
		prod_w     = PROD_W'(diff_q) * PROD_W'(UMAX_U);
		trial_w    = {rem_q, num_lo_q[U_W-1]};
		take_w     = (trial_w >= span_q);
		sub_w      = trial_w - span_q;
		rgb_w      = green_q ? GREEN_RGB : ramp_color(num_lo_q);
		idx_next_w = idx_q + CNT_W'(1);
		last_w     = (idx_next_w == count_q);
		load_out_w = (state_q == B_COLOR) && (!out_valid_q || color.ready);
	end

	// Value store: one write port from the front end, one registered read.
	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			store_q[mem_wr.addr] <= mem_wr.data;
		end
		rd_data_q <= store_q[idx_q[IDX_W-1:0]];
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					lo_q    <= job.lo;
					hi_q    <= job.hi;
					count_q <= job.count;
					trunc_q <= job.trunc;
					span_q  <= span_w;
				end
			end
			B_LOAD: begin
				green_q <= green_w;
				diff_q  <= diff_w[DEV_W-1:0];
				if (green_w || le_w) begin
					num_lo_q <= '0;
				end else if (ge_w) begin
					num_lo_q <= UMAX_U;
				end
			end
			B_MUL: begin
				rem_q     <= prod_w[PROD_W-1:U_W];
				num_lo_q  <= prod_w[U_W-1:0];
				div_cnt_q <= '0;
			end
			B_DIV: begin
				rem_q     <= take_w ? sub_w[DEV_W-1:0] : trial_w[DEV_W-1:0];
				num_lo_q  <= {num_lo_q[U_W-2:0], take_w};
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_rgb_q   <= '0;
			out_trunc_q <= 1'b0;
			out_last_q  <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= load_out_w && last_w;
			if (load_out_w) begin
				out_valid_q <= 1'b1;
			end else if (color.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						idx_q   <= '0;
						state_q <= B_READ;
					end
				end
				B_READ: begin
					state_q <= B_LOAD;
				end
				B_LOAD: begin
					if (green_w || le_w || ge_w) begin
						state_q <= B_COLOR;
					end else begin
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					state_q <= B_DIV;
				end
				B_DIV: begin
					if (div_cnt_q == DIV_CNT_W'(U_W - 1)) begin
						state_q <= B_COLOR;
					end
				end
				B_COLOR: begin
					if (load_out_w) begin
						out_rgb_q   <= rgb_w;
						out_trunc_q <= trunc_q;
						out_last_q  <= last_w;
						idx_q       <= idx_next_w;
						if (last_w) begin
							state_q <= B_IDLE;
						end else begin
							state_q <= B_READ;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	`ADCM_ASSERT_IMP(a_rem_below_span, state_q == B_DIV, {1'b0, rem_q} < span_q)
	`ADCM_ASSERT_IMP(a_u_in_range, (state_q == B_COLOR) && !green_q, num_lo_q <= UMAX_U)
	`ADCM_ASSERT_IMP(a_done_after_last, done_q, out_valid_q && out_last_q)

endmodule

// ----- design/autoscaled_deviation_colormap_unit.sv -----
// Autoscaled deviation colormap: top level. Collects a set of Q16.16
// deviations, picks the scale bounds and streams one RGB colour per item.
// Depends on adcm_pkg, the channel interfaces, adcm_front, adcm_job_fifo, adcm_back.
//
// Load a set on the item channel, one item per cycle, until an item with
// set_last. Up to DEPTH items are kept; later ones are dropped and every
// colour of the set then shows truncated. When the set closes, the scale is
// the manual range if manual_enable is set and manual_min <= manual_max,
// otherwise the min and max of the kept finite items (0,0 if there are
// none). One colour per kept item follows in input order, run_last on the
// final one. An item strictly inside the range passes through store read,
// classify, multiply, 18 steps of the bit-serial divider (one quotient bit
// per cycle) and ramp lookup. Items at or beyond a bound, non-finite items
// and sets with an empty span skip the multiply and divide steps. The item
// channel stalls from the set_last transfer until the final colour of that
// run has entered the output register and the done pulse has cleared the
// pending flag; the output register lets the next colour be computed while
// the current one waits. Configuration writes are taken at any time (ready
// is always high) but must only happen while the block is idle.
module autoscaled_deviation_colormap_unit import adcm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	adcm_item_if.sink    item,
	adcm_color_if.source color,
	adcm_cfg_if.sink     cfg
);

	logic                    manual_enable_q;
	logic signed [DEV_W-1:0] manual_min_q;
	logic signed [DEV_W-1:0] manual_max_q;

	mem_wr_t                 mem_wr;
	job_t                    front_job;
	logic                    front_job_valid;
	logic                    front_job_ready;
	job_t                    back_job;
	logic                    back_job_valid;
	logic                    back_job_ready;
	logic                    run_done;

	// Register file: accept every write, drop indexes beyond the map.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manual_enable_q <= 1'b0;
			manual_min_q    <= '0;
			manual_max_q    <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_MANUAL_ENABLE: manual_enable_q <= cfg.data[0];
				CFG_MANUAL_MIN:    manual_min_q    <= cfg.data;
				CFG_MANUAL_MAX:    manual_max_q    <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Front: collect the set, track bounds, close it into a job.
	adcm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.manual_enable (manual_enable_q),
		.manual_min    (manual_min_q),
		.manual_max    (manual_max_q),
		.mem_wr        (mem_wr),
		.job           (front_job),
		.job_valid     (front_job_valid),
		.job_ready     (front_job_ready),
		.done          (run_done)
	);

	// Job queue: decouple set collection from colour emission.
	adcm_job_fifo u_job_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_job   (front_job),
		.push_valid (front_job_valid),
		.push_ready (front_job_ready),
		.pop_job    (back_job),
		.pop_valid  (back_job_valid),
		.pop_ready  (back_job_ready)
	);

	// Back: walk the store, divide, map to the ramp, drive the colour channel.
	adcm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mem_wr    (mem_wr),
		.job       (back_job),
		.job_valid (back_job_valid),
		.job_ready (back_job_ready),
		.done      (run_done),
		.color     (color)
	);

endmodule
